// File: src/mbtcp_pkg.sv
// shared constants, result type and codes for the modbus tcp response checker
// no dependencies; imported by every module of the block
package mbtcp_pkg;

    localparam int unsigned MAX_WORDS    = 125;
    localparam int unsigned POS_W        = 17;
    localparam int unsigned HEADER_BYTES = 6;
    localparam int unsigned MIN_FRAME    = 9;
    localparam int unsigned RQ_DEPTH     = 4;
    localparam int unsigned RQ_AW        = $clog2(RQ_DEPTH);
    localparam int unsigned RQ_CW        = $clog2(RQ_DEPTH + 1);

    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    localparam logic [7:0] FC_READ     = 8'h03;
    localparam logic [7:0] FC_EXC_FLAG = 8'h80;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_ARG = 2'd1;
    localparam logic [1:0] ST_FRAME   = 2'd2;
    localparam logic [1:0] ST_EXC     = 2'd3;

    localparam logic KIND_WORD   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [1:0] REG_TRANS = 2'd0;
    localparam logic [1:0] REG_UNIT  = 2'd1;
    localparam logic [1:0] REG_WORDS = 2'd2;

    typedef struct packed {
        logic [15:0] exp_trans;
        logic [7:0]  exp_unit;
        logic [7:0]  exp_words;
    } t_cfg;

    typedef struct packed {
        logic        kind;
        logic [6:0]  index;
        logic [15:0] value;
        logic [1:0]  status;
        logic [7:0]  code;
        logic        last;
    } t_result;

endpackage

// File: src/mbtcp_frame.sv
// per-frame parser: captures the mbap header, emits register words and the final status
// depends on mbtcp_pkg
module mbtcp_frame import mbtcp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_accept,
    input  logic [7:0] i_rx_byte,
    input  logic       i_frame_end,
    output logic       o_word_vld,
    output t_result    o_word,
    output logic       o_stat_vld,
    output t_result    o_stat
);

    logic [POS_W-1:0] r_pos,   n_pos;
    logic [15:0]      r_trans, n_trans;
    logic [15:0]      r_proto, n_proto;
    logic [15:0]      r_len,   n_len;
    logic [7:0]       r_unit,  n_unit;
    logic [7:0]       r_fc,    n_fc;
    logic [7:0]       r_bc,    n_bc;
    logic [7:0]       r_pend,  n_pend;

    logic [POS_W-1:0] c_len;
    logic [POS_W-1:0] off;
    logic [15:0]      widx;
    logic             in_payload;
    logic [1:0]       st;
    logic [7:0]       code;

    assign off  = r_pos - POS_W'(MIN_FRAME);
    assign widx = off[POS_W-1:1];
    assign c_len = (r_pos < POS_MAX) ? r_pos + POS_W'(1) : r_pos;

    // header capture and word emission
    always_comb begin
        n_trans    = r_trans;
        n_proto    = r_proto;
        n_len      = r_len;
        n_unit     = r_unit;
        n_fc       = r_fc;
        n_bc       = r_bc;
        n_pend     = r_pend;
        in_payload = 1'b0;
        case (r_pos)
            POS_W'(0), POS_W'(1): n_trans = {r_trans[7:0], i_rx_byte};
            POS_W'(2), POS_W'(3): n_proto = {r_proto[7:0], i_rx_byte};
            POS_W'(4), POS_W'(5): n_len   = {r_len[7:0], i_rx_byte};
            POS_W'(6):            n_unit  = i_rx_byte;
            POS_W'(7):            n_fc    = i_rx_byte;
            POS_W'(8):            n_bc    = i_rx_byte;
            default: begin
                if (r_pos < POS_MAX) begin
                    in_payload = 1'b1;
                    if (!off[0]) begin
                        n_pend = i_rx_byte;
                    end
                end
            end
        endcase
    end

    assign o_word_vld = i_accept && in_payload && off[0]
                        && (widx < {8'd0, i_cfg.exp_words})
                        && (widx < 16'(MAX_WORDS));
    assign o_word = '{kind: KIND_WORD, index: widx[6:0], value: {r_pend, i_rx_byte},
                      status: ST_OK, code: 8'd0, last: 1'b0};

    // frame verdict, checks in priority order
    always_comb begin
        code = 8'd0;
        if (i_cfg.exp_words == 8'd0 || i_cfg.exp_words > 8'(MAX_WORDS)) begin
            st = ST_BAD_ARG;
        end else if (c_len < POS_W'(MIN_FRAME)) begin
            st = ST_FRAME;
        end else if (n_proto != 16'd0) begin
            st = ST_FRAME;
        end else if ({1'b0, n_len} + POS_W'(HEADER_BYTES) != c_len) begin
            st = ST_FRAME;
        end else if (n_trans != i_cfg.exp_trans) begin
            st = ST_FRAME;
        end else if (n_unit != i_cfg.exp_unit) begin
            st = ST_FRAME;
        end else if (n_fc == (FC_READ | FC_EXC_FLAG)) begin
            st   = ST_EXC;
            code = n_bc;
        end else if (n_fc != FC_READ) begin
            st = ST_FRAME;
        end else if (n_bc != {i_cfg.exp_words[6:0], 1'b0}) begin
            st = ST_FRAME;
        end else if (c_len < POS_W'(MIN_FRAME) + {{(POS_W-8){1'b0}}, n_bc}) begin
            st = ST_FRAME;
        end else begin
            st = ST_OK;
        end
    end

    assign o_stat_vld = i_accept && i_frame_end;
    assign o_stat = '{kind: KIND_STATUS, index: 7'd0, value: 16'd0,
                      status: st, code: code, last: 1'b1};

    assign n_pos = i_frame_end ? '0 : c_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_trans <= '0;
            r_proto <= '0;
            r_len   <= '0;
            r_unit  <= '0;
            r_fc    <= '0;
            r_bc    <= '0;
            r_pend  <= '0;
        end else if (i_accept) begin
            r_pos <= n_pos;
            if (i_frame_end) begin
                r_trans <= '0;
                r_proto <= '0;
                r_len   <= '0;
                r_unit  <= '0;
                r_fc    <= '0;
                r_bc    <= '0;
                r_pend  <= '0;
            end else begin
                r_trans <= n_trans;
                r_proto <= n_proto;
                r_len   <= n_len;
                r_unit  <= n_unit;
                r_fc    <= n_fc;
                r_bc    <= n_bc;
                r_pend  <= n_pend;
            end
        end
    end

endmodule

// File: src/mbtcp_rq.sv
// result queue: takes up to two results per cycle, hands out one per beat
// depends on mbtcp_pkg
module mbtcp_rq import mbtcp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push0,
    input  t_result i_data0,
    input  logic    i_push1,
    input  t_result i_data1,
    input  logic    i_pop,
    output logic    o_valid,
    output t_result o_head,
    output logic    o_full2
);

    t_result          r_mem [RQ_DEPTH];
    logic [RQ_AW-1:0] r_wr, n_wr;
    logic [RQ_AW-1:0] r_rd;
    logic [RQ_CW-1:0] r_cnt;
    logic [RQ_CW-1:0] n_push;
    logic             do_pop;

    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd];
    // stall input unless room for two more
    assign o_full2 = (r_cnt > RQ_CW'(RQ_DEPTH - 2));
    assign do_pop  = i_pop && o_valid;
    assign n_push  = RQ_CW'(i_push0) + RQ_CW'(i_push1);
    assign n_wr    = r_wr + RQ_AW'(1);

    always_ff @(posedge i_clk) begin
        if (i_push0) begin
            r_mem[r_wr] <= i_data0;
            if (i_push1) begin
                r_mem[n_wr] <= i_data1;
            end
        end else if (i_push1) begin
            r_mem[r_wr] <= i_data1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + n_push[RQ_AW-1:0];
            r_cnt <= r_cnt + n_push - RQ_CW'(do_pop);
            if (do_pop) begin
                r_rd <= r_rd + RQ_AW'(1);
            end
        end
    end

endmodule

// File: src/modbus_tcp_read_response_check.sv
// Modbus TCP read-holding-registers response checker. One response byte is taken per
// cycle, back to back, while o_stall is low, with i_frame_end on the last byte. Results
// come out one per beat, at the earliest in the cycle after the byte that causes them: a
// register word when its low byte arrives, and one status beat (o_last high) on the frame's
// last byte, which comes right after a word from that same byte in the four-entry result
// queue; o_stall rises while it holds more than two, which only happens when the consumer
// stalls, so the sustained rate is one byte per cycle. Words are tentative: drop them
// unless the status is ok. Write the expected ids and word count over the apb port only
// while no frame is in flight.
// depends on mbtcp_pkg, mbtcp_frame, mbtcp_rq
module modbus_tcp_read_response_check import mbtcp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_frame_end,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_out_kind,
    output logic [6:0]  o_word_index,
    output logic [15:0] o_word_value,
    output logic [1:0]  o_frame_status,
    output logic [7:0]  o_exception_code,
    output logic        o_last
);

    t_cfg    r_cfg;
    logic    wr_en;
    logic    accept;
    logic    word_vld;
    logic    stat_vld;
    t_result word_res;
    t_result stat_res;
    t_result head;
    logic    full2;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.exp_trans <= 16'd0;
            r_cfg.exp_unit  <= 8'd0;
            r_cfg.exp_words <= 8'd1;
        end else if (wr_en) begin
            case (paddr[3:2])
                REG_TRANS: r_cfg.exp_trans <= pwdata[15:0];
                REG_UNIT:  r_cfg.exp_unit  <= pwdata[7:0];
                REG_WORDS: r_cfg.exp_words <= pwdata[7:0];
                default:   ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_TRANS: prdata = {16'd0, r_cfg.exp_trans};
            REG_UNIT:  prdata = {24'd0, r_cfg.exp_unit};
            REG_WORDS: prdata = {24'd0, r_cfg.exp_words};
            default:   prdata = 32'd0;
        endcase
    end

    assign o_stall = full2;
    assign accept  = i_valid && !full2;

    mbtcp_frame u_frame (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_accept    (accept),
        .i_rx_byte   (i_rx_byte),
        .i_frame_end (i_frame_end),
        .o_word_vld  (word_vld),
        .o_word      (word_res),
        .o_stat_vld  (stat_vld),
        .o_stat      (stat_res)
    );

    mbtcp_rq u_rq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push0 (word_vld),
        .i_data0 (word_res),
        .i_push1 (stat_vld),
        .i_data1 (stat_res),
        .i_pop   (!i_stall),
        .o_valid (o_valid),
        .o_head  (head),
        .o_full2 (full2)
    );

    assign o_out_kind       = head.kind;
    assign o_word_index     = head.index;
    assign o_word_value     = head.value;
    assign o_frame_status   = head.status;
    assign o_exception_code = head.code;
    assign o_last           = head.last;

endmodule

// File: src/mbtcp_chk.sv
// port-level checks on the response checker's result stream
// depends on mbtcp_pkg; bound to modbus_tcp_read_response_check
module mbtcp_chk import mbtcp_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic        o_out_kind,
    input logic [6:0]  o_word_index,
    input logic [15:0] o_word_value,
    input logic [1:0]  o_frame_status,
    input logic [7:0]  o_exception_code,
    input logic        o_last
);

    // queue is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result beat right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    a_status_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_kind == KIND_STATUS |->
            o_last && o_word_index == 7'd0 && o_word_value == 16'd0)
        else $error("malformed status beat");

    a_word_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_kind == KIND_WORD |->
            !o_last && o_frame_status == ST_OK && o_exception_code == 8'd0
            && o_word_index < 7'(MAX_WORDS))
        else $error("malformed word beat");

    a_exc_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_exception_code != 8'd0 |-> o_frame_status == ST_EXC)
        else $error("exception code without exception status");

endmodule

bind modbus_tcp_read_response_check mbtcp_chk u_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_out_kind       (o_out_kind),
    .o_word_index     (o_word_index),
    .o_word_value     (o_word_value),
    .o_frame_status   (o_frame_status),
    .o_exception_code (o_exception_code),
    .o_last           (o_last)
);
